@@ hdl/rmeu_pkg.sv @@
`default_nettype none

package rmeu_pkg;

  // Operation codes of one instruction.
  typedef enum logic [3:0] {
    OP_ADDR = 4'd0,
    OP_ADDI = 4'd1,
    OP_MULR = 4'd2,
    OP_MULI = 4'd3,
    OP_BANR = 4'd4,
    OP_BANI = 4'd5,
    OP_BORR = 4'd6,
    OP_BORI = 4'd7,
    OP_SETR = 4'd8,
    OP_SETI = 4'd9,
    OP_GTIR = 4'd10,
    OP_GTRI = 4'd11,
    OP_GTRR = 4'd12,
    OP_EQIR = 4'd13,
    OP_EQRI = 4'd14,
    OP_EQRR = 4'd15
  } op_e;

  // Result status codes.
  localparam logic [2:0] ST_RUN    = 3'd0;
  localparam logic [2:0] ST_OUT    = 3'd1;
  localparam logic [2:0] ST_REPEAT = 3'd2;
  localparam logic [2:0] ST_FULL   = 3'd3;
  localparam logic [2:0] ST_BADREG = 3'd4;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_POINTER_REG = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROGRAM_LEN = 2'd1;

  // Microprogram step addresses.
  localparam int unsigned UPC_W = 4;
  localparam logic [UPC_W-1:0] U_IDLE   = 4'd0;
  localparam logic [UPC_W-1:0] U_CHECK  = 4'd1;
  localparam logic [UPC_W-1:0] U_RDA    = 4'd2;
  localparam logic [UPC_W-1:0] U_RDB    = 4'd3;
  localparam logic [UPC_W-1:0] U_EXEC   = 4'd4;
  localparam logic [UPC_W-1:0] U_SCAN   = 4'd5;
  localparam logic [UPC_W-1:0] U_APPEND = 4'd6;
  localparam logic [UPC_W-1:0] U_COMMIT = 4'd7;
  localparam logic [UPC_W-1:0] U_DONE   = 4'd8;

  // Datapath action of one control word.
  typedef enum logic [3:0] {
    ACT_WAIT,
    ACT_CHECK,
    ACT_READ_A,
    ACT_READ_B,
    ACT_EXEC,
    ACT_SCAN,
    ACT_APPEND,
    ACT_COMMIT,
    ACT_EMIT
  } act_e;

  // Jump condition of one control word.
  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_ACCEPT,
    COND_EXCEPT,
    COND_EQRR,
    COND_SCAN_END,
    COND_FULL,
    COND_OUT_FREE
  } cond_e;

  typedef struct packed {
    act_e             act;
    cond_e            cond;
    logic [UPC_W-1:0] tgt;   // taken when the condition holds
    logic [UPC_W-1:0] fall;  // taken otherwise
  } ctrl_t;

  function automatic ctrl_t ucode_rom(input logic [UPC_W-1:0] upc);
    ctrl_t w;
    w = '{act: ACT_WAIT, cond: COND_ACCEPT, tgt: U_CHECK, fall: U_IDLE};
    unique case (upc)
      U_IDLE:   w = '{act: ACT_WAIT,   cond: COND_ACCEPT,   tgt: U_CHECK,  fall: U_IDLE};
      U_CHECK:  w = '{act: ACT_CHECK,  cond: COND_EXCEPT,   tgt: U_DONE,   fall: U_RDA};
      U_RDA:    w = '{act: ACT_READ_A, cond: COND_ALWAYS,   tgt: U_RDB,    fall: U_RDB};
      U_RDB:    w = '{act: ACT_READ_B, cond: COND_ALWAYS,   tgt: U_EXEC,   fall: U_EXEC};
      U_EXEC:   w = '{act: ACT_EXEC,   cond: COND_EQRR,     tgt: U_SCAN,   fall: U_COMMIT};
      U_SCAN:   w = '{act: ACT_SCAN,   cond: COND_SCAN_END, tgt: U_APPEND, fall: U_SCAN};
      U_APPEND: w = '{act: ACT_APPEND, cond: COND_FULL,     tgt: U_DONE,   fall: U_COMMIT};
      U_COMMIT: w = '{act: ACT_COMMIT, cond: COND_ALWAYS,   tgt: U_DONE,   fall: U_DONE};
      U_DONE:   w = '{act: ACT_EMIT,   cond: COND_OUT_FREE, tgt: U_IDLE,   fall: U_DONE};
      default:  w = '{act: ACT_WAIT,   cond: COND_ALWAYS,   tgt: U_IDLE,   fall: U_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

@@ hdl/register_machine_execute_unit_core.sv @@
// Execute unit of a small register machine whose instruction pointer is bound
// to one of its registers. The fetch side sends one decoded instruction per
// request on the input channel (valid/ready); the unit runs it on its register
// file and returns one result per request on the output channel: the next
// pointer, a status code, and the value appended to the seen-value store by
// an eqrr instruction. Two configuration registers, the bound register index
// and the program length, are written through a separate valid/ready port
// that is always ready; they are meant to change only while the unit is idle.
// One request is worked at a time by a microprogram of nine steps. A request
// that hits an exception (stopped machine, pointer outside the program, bad
// register index) goes from check to result; a normal request runs check, both
// reads, execute, commit and result; an eqrr scans and appends after execute,
// its scan growing with the number of values already in the seen store,
// because the store is one memory scanned one entry per cycle. The unit is
// ready again in the cycle after the result is loaded. The result sits in an
// output register, so a stalled receiver only blocks the unit when a second
// result is ready to be loaded. Reset clears the registers, the pointer, the
// stop flag and the store's fill count; the store itself needs no clearing.
`default_nettype none

module register_machine_execute_unit_core
  import rmeu_pkg::*;
#(
  parameter int unsigned NUM_REGS   = 6,
  parameter int unsigned SEEN_DEPTH = 4096
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // Configuration writes
  input  wire logic                 cfg_valid_i,
  output      logic                 cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [15:0]          cfg_data_i,
  // Instruction requests
  input  wire logic                 in_valid_i,
  output      logic                 in_ready_o,
  input  wire logic [3:0]           operation_i,
  input  wire logic signed [31:0]   operand_first_i,
  input  wire logic signed [31:0]   operand_second_i,
  input  wire logic [2:0]           destination_i,
  // Results
  output      logic                 out_valid_o,
  input  wire logic                 out_ready_i,
  output      logic signed [31:0]   next_pointer_o,
  output      logic [2:0]           status_o,
  output      logic                 recorded_valid_o,
  output      logic signed [31:0]   recorded_value_o
);

  localparam int unsigned RW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int unsigned AW = $clog2(SEEN_DEPTH);
  localparam int unsigned CW = $clog2(SEEN_DEPTH + 1);

  // Configuration.
  logic [2:0]  ptr_reg_q;
  logic [15:0] prog_len_q;

  // Sequencer.
  logic [UPC_W-1:0] upc_q, upc_d;
  ctrl_t            cw;
  logic             cond;

  // Latched instruction.
  op_e         op_q, op_d;
  logic [31:0] a_q, a_d, b_q, b_d;
  logic [2:0]  dst_q, dst_d;

  // Architectural state.
  logic [31:0] rf_q [NUM_REGS];
  logic [31:0] rf_d [NUM_REGS];
  logic [31:0] ip_q, ip_d;
  logic        stopped_q, stopped_d;
  logic [CW-1:0] seen_cnt_q, seen_cnt_d;

  // Working registers.
  logic [31:0] opa_q, opa_d, opb_q, opb_d, res_q, res_d;
  logic [CW-1:0] scan_idx_q, scan_idx_d;
  logic        pend_q, pend_d, hit_q, hit_d;
  logic [31:0] next_q, next_d;
  logic [2:0]  status_q, status_d;
  logic        rec_valid_q, rec_valid_d;
  logic [31:0] rec_value_q, rec_value_d;

  // Output register.
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_next_q, out_next_d, out_rec_value_q, out_rec_value_d;
  logic [2:0]  out_status_q, out_status_d;
  logic        out_rec_valid_q, out_rec_valid_d;

  // Seen-value store.
  logic [31:0] seen_mem [SEEN_DEPTH];
  logic [31:0] mem_rdata_q;
  logic        mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0] mem_wdata;

  // Decode helpers.
  logic a_reg, b_reg, bad, in_prog_ip, except, match, scan_end, store_full, out_free;
  logic [RW-1:0] ptr_idx, dst_idx, rd_idx;
  logic [31:0] rd_val, new_ip;

  function automatic logic in_program(input logic [31:0] p, input logic [15:0] len);
    return !p[31] && (p < {16'd0, len});
  endfunction

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (upc_q == U_IDLE);

  assign cw = ucode_rom(upc_q);

  // Which operand fields name registers.
  assign a_reg = !(op_q == OP_SETI || op_q == OP_GTIR || op_q == OP_EQIR);
  assign b_reg = (op_q == OP_ADDR) || (op_q == OP_MULR) || (op_q == OP_BANR) ||
                 (op_q == OP_BORR) || (op_q == OP_GTIR) || (op_q == OP_GTRR) ||
                 (op_q == OP_EQIR) || (op_q == OP_EQRR);

  assign bad = (32'(ptr_reg_q) >= 32'(NUM_REGS)) || (32'(dst_q) >= 32'(NUM_REGS)) ||
               (a_reg && (a_q >= 32'(NUM_REGS))) || (b_reg && (b_q >= 32'(NUM_REGS)));
  assign in_prog_ip = in_program(ip_q, prog_len_q);
  assign except = stopped_q || !in_prog_ip || bad;

  assign ptr_idx = RW'(ptr_reg_q);
  assign dst_idx = RW'(dst_q);

  // Single register read port. The bound register reads as the current
  // pointer, which is what it holds once the instruction starts.
  assign rd_idx = (cw.act == ACT_READ_A) ? RW'(a_q) : RW'(b_q);
  assign rd_val = (rd_idx == ptr_idx) ? ip_q : rf_q[rd_idx];

  assign match      = pend_q && (mem_rdata_q == opa_q);
  assign scan_end   = match || (scan_idx_q == seen_cnt_q);
  assign store_full = !hit_q && (seen_cnt_q == CW'(SEEN_DEPTH));
  assign out_free   = !out_valid_q || out_ready_i;

  assign new_ip = ((dst_idx == ptr_idx) ? res_q : ip_q) + 32'd1;

  always_comb begin
    unique case (cw.cond)
      COND_ALWAYS:   cond = 1'b1;
      COND_ACCEPT:   cond = in_valid_i;
      COND_EXCEPT:   cond = except;
      COND_EQRR:     cond = (op_q == OP_EQRR);
      COND_SCAN_END: cond = scan_end;
      COND_FULL:     cond = store_full;
      COND_OUT_FREE: cond = out_free;
      default:       cond = 1'b1;
    endcase
    upc_d = cond ? cw.tgt : cw.fall;
  end

  always_comb begin
    op_d        = op_q;
    a_d         = a_q;
    b_d         = b_q;
    dst_d       = dst_q;
    rf_d        = rf_q;
    ip_d        = ip_q;
    stopped_d   = stopped_q;
    seen_cnt_d  = seen_cnt_q;
    opa_d       = opa_q;
    opb_d       = opb_q;
    res_d       = res_q;
    scan_idx_d  = scan_idx_q;
    pend_d      = pend_q;
    hit_d       = hit_q;
    next_d      = next_q;
    status_d    = status_q;
    rec_valid_d = rec_valid_q;
    rec_value_d = rec_value_q;
    mem_we      = 1'b0;
    mem_waddr   = seen_cnt_q[AW-1:0];
    mem_wdata   = opa_q;

    out_valid_d     = out_valid_q && !out_ready_i;
    out_next_d      = out_next_q;
    out_status_d    = out_status_q;
    out_rec_valid_d = out_rec_valid_q;
    out_rec_value_d = out_rec_value_q;

    unique case (cw.act)
      ACT_WAIT: begin
        if (in_valid_i) begin
          op_d  = op_e'(operation_i);
          a_d   = operand_first_i;
          b_d   = operand_second_i;
          dst_d = destination_i;
        end
      end
      ACT_CHECK: begin
        rec_valid_d = 1'b0;
        rec_value_d = '0;
        hit_d       = 1'b0;
        next_d      = ip_q;
        if (stopped_q) begin
          status_d = ST_REPEAT;
        end else if (!in_prog_ip) begin
          status_d = ST_OUT;
        end else begin
          status_d = ST_BADREG;
        end
      end
      ACT_READ_A: opa_d = a_reg ? rd_val : a_q;
      ACT_READ_B: opb_d = b_reg ? rd_val : b_q;
      ACT_EXEC: begin
        scan_idx_d = '0;
        pend_d     = 1'b0;
        unique case (op_q)
          OP_ADDR, OP_ADDI: res_d = opa_q + opb_q;
          OP_MULR, OP_MULI: res_d = opa_q * opb_q;
          OP_BANR, OP_BANI: res_d = opa_q & opb_q;
          OP_BORR, OP_BORI: res_d = opa_q | opb_q;
          OP_SETR, OP_SETI: res_d = opa_q;
          OP_GTIR, OP_GTRI, OP_GTRR:
            res_d = {31'd0, $signed(opa_q) > $signed(opb_q)};
          OP_EQIR, OP_EQRI, OP_EQRR:
            res_d = {31'd0, opa_q == opb_q};
          default: res_d = opa_q;
        endcase
      end
      ACT_SCAN: begin
        // One store entry is read per cycle; its data is compared in the following cycle.
        if (match) begin
          hit_d = 1'b1;
        end
        pend_d = !scan_end;
        if (!scan_end) begin
          scan_idx_d = scan_idx_q + CW'(1);
        end
      end
      ACT_APPEND: begin
        if (store_full) begin
          status_d = ST_FULL;
          next_d   = ip_q;
        end else if (!hit_q) begin
          mem_we      = 1'b1;
          seen_cnt_d  = seen_cnt_q + CW'(1);
          rec_valid_d = 1'b1;
          rec_value_d = opa_q;
        end
      end
      ACT_COMMIT: begin
        rf_d[ptr_idx] = ip_q;
        if (hit_q) begin
          stopped_d = 1'b1;
          status_d  = ST_REPEAT;
          next_d    = ip_q;
        end else begin
          rf_d[dst_idx] = res_q;
          ip_d          = new_ip;
          next_d        = new_ip;
          status_d      = in_program(new_ip, prog_len_q) ? ST_RUN : ST_OUT;
        end
      end
      ACT_EMIT: begin
        if (out_free) begin
          out_valid_d     = 1'b1;
          out_next_d      = next_q;
          out_status_d    = status_q;
          out_rec_valid_d = rec_valid_q;
          out_rec_value_d = rec_value_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_reg_q   <= '0;
      prog_len_q  <= '0;
      upc_q       <= U_IDLE;
      for (int i = 0; i < NUM_REGS; i++) begin
        rf_q[i] <= '0;
      end
      ip_q        <= '0;
      stopped_q   <= 1'b0;
      seen_cnt_q  <= '0;
      pend_q      <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == CFG_POINTER_REG) begin
          ptr_reg_q <= cfg_data_i[2:0];
        end else if (cfg_index_i == CFG_PROGRAM_LEN) begin
          prog_len_q <= cfg_data_i;
        end
      end
      upc_q       <= upc_d;
      rf_q        <= rf_d;
      ip_q        <= ip_d;
      stopped_q   <= stopped_d;
      seen_cnt_q  <= seen_cnt_d;
      pend_q      <= pend_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    op_q            <= op_d;
    a_q             <= a_d;
    b_q             <= b_d;
    dst_q           <= dst_d;
    opa_q           <= opa_d;
    opb_q           <= opb_d;
    res_q           <= res_d;
    scan_idx_q      <= scan_idx_d;
    next_q          <= next_d;
    status_q        <= status_d;
    rec_valid_q     <= rec_valid_d;
    rec_value_q     <= rec_value_d;
    out_next_q      <= out_next_d;
    out_status_q    <= out_status_d;
    out_rec_valid_q <= out_rec_valid_d;
    out_rec_value_q <= out_rec_value_d;
  end

  // Seen-value store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      seen_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_q <= seen_mem[scan_idx_q[AW-1:0]];
  end

  assign out_valid_o      = out_valid_q;
  assign next_pointer_o   = out_next_q;
  assign status_o         = out_status_q;
  assign recorded_valid_o = out_rec_valid_q;
  assign recorded_value_o = out_rec_value_q;

endmodule

`default_nettype wire

@@ hdl/rmeu_checker.sv @@
`default_nettype none

module rmeu_checker
  import rmeu_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_ready_o,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i,
  input wire logic signed [31:0] next_pointer_o,
  input wire logic [2:0]        status_o,
  input wire logic              recorded_valid_o,
  input wire logic signed [31:0] recorded_value_o
);

  // Status codes stay within the defined set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o <= ST_BADREG))
    else $error("status code out of range");

  // A value is only recorded by a step that ran normally.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && recorded_valid_o) |-> (status_o == ST_RUN || status_o == ST_OUT))
    else $error("value recorded on an aborted step");

  // Without a recorded value the value field reads zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !recorded_valid_o) |-> (recorded_value_o == 32'sd0))
    else $error("recorded value set without recorded flag");

  // One request at a time: the unit is busy right after taking one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request taken while another is in work");

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(next_pointer_o)))
    else $error("stalled result changed");

endmodule

bind register_machine_execute_unit_core rmeu_checker u_rmeu_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .next_pointer_o   (next_pointer_o),
  .status_o         (status_o),
  .recorded_valid_o (recorded_valid_o),
  .recorded_value_o (recorded_value_o)
);

`default_nettype wire
